>>> sv/serial_bank_switch_mapper_defines.svh
// Assertion macros for the checker file of the bank switch mapper.
`ifndef SERIAL_BANK_SWITCH_MAPPER_DEFINES_SVH
`define SERIAL_BANK_SWITCH_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsm assertion failed");

`endif

>>> sv/sbsm_pkg.sv
`timescale 1ns / 1ps

package sbsm_pkg;

    // Serial loader commits on this write.
    localparam int LOADER_WRITES = 5;
    localparam int LOAD_CNT_W    = $clog2(LOADER_WRITES + 1);

    localparam int REG_W      = 5;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int OFFSET_W   = 18;
    localparam int BANK_CNT_W = 5;

    localparam logic [REG_W-1:0]      CTRL_RESET      = 5'h0C;
    localparam logic [BANK_CNT_W-1:0] BANK_CNT_RESET  = 5'd16;
    localparam logic [BANK_CNT_W-1:0] BANK_CNT_MAX    = 5'd16;
    localparam logic [BANK_CNT_W-1:0] BANK_CNT_MIN    = 5'd1;

    typedef enum logic [1:0] {
        REQ_CPU_READ  = 2'd0,
        REQ_CPU_WRITE = 2'd1,
        REQ_PPU_READ  = 2'd2,
        REQ_PPU_WRITE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_ROM = 2'd1,
        TGT_WRAM    = 2'd2,
        TGT_PATTERN = 2'd3
    } t_target;

    // Register selected by address bits 14..13 on a committing write.
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_PAT_LOW  = 2'd1,
        SEL_PAT_HIGH = 2'd2,
        SEL_PROGRAM  = 2'd3
    } t_reg_sel;

endpackage

>>> sv/serial_bank_switch_mapper.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                | Payload
// request   | in        | i_in_valid / o_in_ready   | i_req_type, i_address, i_write_data
// result    | out       | o_out_valid / i_out_ready | o_target, o_mem_offset, o_mem_write,
//           |           |                          | o_mem_data, o_mirroring, o_bank_fault
// config    | in        | i_cfg_we                 | i_cfg_data (prg_bank_count)
//
// Each request passes through the input register, then the result register.
// One request per cycle is sustained while i_out_ready holds; the decode and mapper register
// update sit between the input register and the result register.
// Reset (synchronous, active low) empties both stages and restores the mapper registers.
// A stalled result holds; the input stage keeps accepting while the result stage can drain.

module serial_bank_switch_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [sbsm_pkg::ADDR_W-1:0]    i_address,
    input  logic [sbsm_pkg::DATA_W-1:0]    i_write_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_target,
    output logic [sbsm_pkg::OFFSET_W-1:0]  o_mem_offset,
    output logic                           o_mem_write,
    output logic [sbsm_pkg::DATA_W-1:0]    o_mem_data,
    output logic [1:0]                     o_mirroring,
    output logic                           o_bank_fault,
    input  logic                           i_cfg_we,
    input  logic [sbsm_pkg::BANK_CNT_W-1:0] i_cfg_data
);
    import sbsm_pkg::*;

    // Input stage.
    logic              r_s1_valid;
    t_req_type         r_s1_type;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [DATA_W-1:0] r_s1_data;

    // Mapper state.
    logic [REG_W-1:0]      r_shift, n_shift;
    logic [LOAD_CNT_W-1:0] r_load_cnt, n_load_cnt;
    logic [REG_W-1:0]      r_control, n_control;
    logic [REG_W-1:0]      r_pat_low, n_pat_low;
    logic [REG_W-1:0]      r_pat_high, n_pat_high;
    logic [REG_W-1:0]      r_program, n_program;
    logic [BANK_CNT_W-1:0] r_bank_cnt;

    // Result stage.
    logic                r_out_valid;
    t_target             r_target, n_target;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic                r_mem_write, n_mem_write;
    logic [DATA_W-1:0]   r_mem_data, n_mem_data;
    logic [1:0]          r_mirroring, n_mirroring;
    logic                r_fault, n_fault;

    logic                  s2_space;
    logic                  s1_fire;
    logic                  in_fire;
    logic [BANK_CNT_W-1:0] bank_cnt;
    logic [3:0]            prg_bank;
    logic [REG_W-1:0]      shifted;
    logic [REG_W-1:0]      pat_bank;

    // Stage handshakes.
    assign s2_space   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s2_space;
    assign o_in_ready = !r_s1_valid || s2_space;
    assign in_fire    = i_in_valid && o_in_ready;

    // Bank count clamped to the range the banking logic supports.
    always_comb begin
        if (r_bank_cnt < BANK_CNT_MIN) begin
            bank_cnt = BANK_CNT_MIN;
        end else if (r_bank_cnt > BANK_CNT_MAX) begin
            bank_cnt = BANK_CNT_MAX;
        end else begin
            bank_cnt = r_bank_cnt;
        end
    end

    // Program bank for a CPU read at 0x8000 and above; bit 14 picks the upper half.
    always_comb begin
        if (!r_control[3]) begin
            prg_bank = {r_program[3:1], r_s1_addr[14]};
        end else if (r_control[2]) begin
            prg_bank = r_s1_addr[14] ? 4'(bank_cnt - BANK_CNT_MIN) : r_program[3:0];
        end else begin
            prg_bank = r_s1_addr[14] ? r_program[3:0] : 4'd0;
        end
    end

    assign shifted  = {r_s1_data[0], r_shift[REG_W-1:1]};
    assign pat_bank = r_s1_addr[12] ? r_pat_high : r_pat_low;

    // Request decode, serial loader and result formation.
    always_comb begin
        n_shift     = r_shift;
        n_load_cnt  = r_load_cnt;
        n_control   = r_control;
        n_pat_low   = r_pat_low;
        n_pat_high  = r_pat_high;
        n_program   = r_program;
        n_target    = TGT_NONE;
        n_offset    = '0;
        n_mem_write = 1'b0;
        n_fault     = 1'b0;

        if (!r_s1_type[1]) begin
            if (r_s1_addr[15]) begin
                if (r_s1_type == REQ_CPU_WRITE) begin
                    if (r_s1_data[7]) begin
                        // Loader reset also fixes the last program bank.
                        n_shift    = '0;
                        n_load_cnt = '0;
                        n_control  = r_control | CTRL_RESET;
                    end else if (r_load_cnt == LOAD_CNT_W'(LOADER_WRITES - 1)) begin
                        n_shift    = '0;
                        n_load_cnt = '0;
                        unique case (t_reg_sel'(r_s1_addr[14:13]))
                            SEL_CONTROL:  n_control  = shifted;
                            SEL_PAT_LOW:  n_pat_low  = shifted;
                            SEL_PAT_HIGH: n_pat_high = shifted;
                            SEL_PROGRAM:  n_program  = shifted;
                            default:      n_program  = shifted;
                        endcase
                    end else begin
                        n_shift    = shifted;
                        n_load_cnt = r_load_cnt + LOAD_CNT_W'(1);
                    end
                end else begin
                    n_target = TGT_PRG_ROM;
                    n_offset = {prg_bank, r_s1_addr[13:0]};
                    n_fault  = {1'b0, prg_bank} >= bank_cnt;
                end
            end else if (r_s1_addr[14:13] == 2'b11) begin
                // Work RAM window 0x6000..0x7FFF.
                n_target    = TGT_WRAM;
                n_offset    = {5'd0, r_s1_addr[12:0]};
                n_mem_write = (r_s1_type == REQ_CPU_WRITE);
            end
        end else if (r_s1_addr[15:13] == 3'd0) begin
            n_target    = TGT_PATTERN;
            n_mem_write = (r_s1_type == REQ_PPU_WRITE);
            if (r_control[4]) begin
                n_offset = {1'b0, pat_bank, r_s1_addr[11:0]};
            end else begin
                n_offset = {1'b0, r_pat_low[4:1], r_s1_addr[12:0]};
            end
        end

        n_mem_data  = n_mem_write ? r_s1_data : '0;
        n_mirroring = n_control[1:0];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= '0;
            r_load_cnt  <= '0;
            r_control   <= CTRL_RESET;
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_program   <= '0;
            r_bank_cnt  <= BANK_CNT_RESET;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_shift    <= n_shift;
                r_load_cnt <= n_load_cnt;
                r_control  <= n_control;
                r_pat_low  <= n_pat_low;
                r_pat_high <= n_pat_high;
                r_program  <= n_program;
            end
            if (i_cfg_we) begin
                r_bank_cnt <= i_cfg_data;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_type <= t_req_type'(i_req_type);
            r_s1_addr <= i_address;
            r_s1_data <= i_write_data;
        end
        if (s1_fire) begin
            r_target    <= n_target;
            r_offset    <= n_offset;
            r_mem_write <= n_mem_write;
            r_mem_data  <= n_mem_data;
            r_mirroring <= n_mirroring;
            r_fault     <= n_fault;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_target     = r_target;
    assign o_mem_offset = r_offset;
    assign o_mem_write  = r_mem_write;
    assign o_mem_data   = r_mem_data;
    assign o_mirroring  = r_mirroring;
    assign o_bank_fault = r_fault;

endmodule

>>> sv/sbsm_checker.sv
`timescale 1ns / 1ps
`include "serial_bank_switch_mapper_defines.svh"

module sbsm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic [1:0]                      i_req_type,
    input logic [sbsm_pkg::ADDR_W-1:0]     i_address,
    input logic [sbsm_pkg::DATA_W-1:0]     i_write_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [1:0]                      o_target,
    input logic [sbsm_pkg::OFFSET_W-1:0]   o_mem_offset,
    input logic                            o_mem_write,
    input logic [sbsm_pkg::DATA_W-1:0]     o_mem_data,
    input logic [1:0]                      o_mirroring,
    input logic                            o_bank_fault,
    input logic                            i_cfg_we,
    input logic [sbsm_pkg::BANK_CNT_W-1:0] i_cfg_data
);
    import sbsm_pkg::*;

    // A stalled result stays offered.
    `SBSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Memory writes only go to work RAM or pattern memory.
    `SBSM_ASSERT_NOW(a_write_target, i_clk, i_rst_n, o_out_valid && o_mem_write, (o_target == TGT_WRAM) || (o_target == TGT_PATTERN))

    // Write data is zero on results that do not write.
    `SBSM_ASSERT_NOW(a_data_zero, i_clk, i_rst_n, o_out_valid && !o_mem_write, o_mem_data == '0)

    // A bank fault only comes with a program ROM access.
    `SBSM_ASSERT_NOW(a_fault_prg, i_clk, i_rst_n, o_out_valid && o_bank_fault, o_target == TGT_PRG_ROM)

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (.*);

>>> verif/tb_serial_bank_switch_mapper.sv
`timescale 1ns / 1ps

module tb_serial_bank_switch_mapper;
    import sbsm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // One translated access as the block reports it.
    typedef struct packed {
        logic [1:0]          target;
        logic [OFFSET_W-1:0] offset;
        logic                mem_wr;
        logic [DATA_W-1:0]   data;
        logic [1:0]          mirror;
        logic                fault;
    } mapper_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_req_type = REQ_CPU_READ;
    logic [ADDR_W-1:0]     i_address = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_target;
    logic [OFFSET_W-1:0]   o_mem_offset;
    logic                  o_mem_write;
    logic [DATA_W-1:0]     o_mem_data;
    logic [1:0]            o_mirroring;
    logic                  o_bank_fault;
    logic                  i_cfg_we = 1'b0;
    logic [BANK_CNT_W-1:0] i_cfg_data = BANK_CNT_RESET;

    // Shadow copy of the mapper registers and the bank count.
    logic [REG_W-1:0]      ld_shift;
    logic [LOAD_CNT_W-1:0] ld_count;
    logic [REG_W-1:0]      ctrl_reg;
    logic [REG_W-1:0]      chr_lo;
    logic [REG_W-1:0]      chr_hi;
    logic [REG_W-1:0]      prg_sel;
    logic [BANK_CNT_W-1:0] bank_count_cfg;

    mapper_result_t pending_maps[$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             no_idle = 1'b0;

    serial_bank_switch_mapper u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_target     (o_target),
        .o_mem_offset (o_mem_offset),
        .o_mem_write  (o_mem_write),
        .o_mem_data   (o_mem_data),
        .o_mirroring  (o_mirroring),
        .o_bank_fault (o_bank_fault),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Most gaps are short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Translate one access and update the shadow registers the same way the mapper does.
    function automatic void map_access(input logic [1:0] rt, input logic [ADDR_W-1:0] a,
                                       input logic [DATA_W-1:0] d, output mapper_result_t r);
        logic [BANK_CNT_W-1:0] cnt;
        logic [REG_W-1:0]      bank;
        r = '0;
        if (bank_count_cfg < BANK_CNT_MIN) cnt = BANK_CNT_MIN;
        else if (bank_count_cfg > BANK_CNT_MAX) cnt = BANK_CNT_MAX;
        else cnt = bank_count_cfg;

        if (rt == REQ_CPU_READ || rt == REQ_CPU_WRITE) begin
            if (a >= 16'h8000) begin
                if (rt == REQ_CPU_WRITE) begin
                    // A write with bit 7 set clears the loader and fixes the last bank.
                    if (d[7]) begin
                        ld_shift = '0;
                        ld_count = '0;
                        ctrl_reg = ctrl_reg | 5'h0C;
                    end else begin
                        ld_shift = {d[0], ld_shift[REG_W-1:1]};
                        ld_count = ld_count + 1'b1;
                        if (ld_count >= LOADER_WRITES) begin
                            case (t_reg_sel'(a[14:13]))
                                SEL_CONTROL:  ctrl_reg = ld_shift;
                                SEL_PAT_LOW:  chr_lo = ld_shift;
                                SEL_PAT_HIGH: chr_hi = ld_shift;
                                default:      prg_sel = ld_shift;
                            endcase
                            ld_shift = '0;
                            ld_count = '0;
                        end
                    end
                end else begin
                    // Program bank selection by mode; bit 14 picks the upper half.
                    if (!ctrl_reg[3]) bank = {1'b0, prg_sel[3:1], a[14]};
                    else if (ctrl_reg[2]) bank = a[14] ? cnt - 1'b1 : {1'b0, prg_sel[3:0]};
                    else bank = a[14] ? {1'b0, prg_sel[3:0]} : '0;
                    r.target = TGT_PRG_ROM;
                    r.offset = {bank[3:0], a[13:0]};
                    r.fault  = (bank >= cnt);
                end
            end else if (a >= 16'h6000) begin
                r.target = TGT_WRAM;
                r.offset = OFFSET_W'(a - 16'h6000);
                r.mem_wr = (rt == REQ_CPU_WRITE);
            end
        end else if (a < 16'h2000) begin
            // Pattern memory: two 4 KiB banks or one 8 KiB bank.
            r.target = TGT_PATTERN;
            if (ctrl_reg[4]) r.offset = {1'b0, (a[12] ? chr_hi : chr_lo), a[11:0]};
            else r.offset = {1'b0, chr_lo[4:1], a[12:0]};
            r.mem_wr = (rt == REQ_PPU_WRITE);
        end
        r.data   = r.mem_wr ? d : '0;
        r.mirror = ctrl_reg[1:0];
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Predict every accepted request and check every accepted result against the oldest one.
    always @(posedge i_clk) begin
        mapper_result_t predicted;
        mapper_result_t oldest;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                map_access(i_req_type, i_address, i_write_data, predicted);
                pending_maps.push_back(predicted);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_maps.size() == 0) begin
                    $error("result arrived with no request pending");
                    error_count++;
                end else begin
                    oldest = pending_maps.pop_front();
                    check_field("target", oldest.target, o_target);
                    check_field("mem_offset", oldest.offset, o_mem_offset);
                    check_field("mem_write", oldest.mem_wr, o_mem_write);
                    check_field("mem_data", oldest.data, o_mem_data);
                    check_field("mirroring", oldest.mirror, o_mirroring);
                    check_field("bank_fault", oldest.fault, o_bank_fault);
                end
            end
        end
    end

    // Result side stalls at random.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("serial_bank_switch_mapper test failed");
            $finish;
        end
    end

    // Send one request and wait until it is accepted.
    task automatic send_request(input logic [1:0] rt, input logic [ADDR_W-1:0] a,
                                input logic [DATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= rt;
        i_address    <= a;
        i_write_data <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every pending request has produced its result.
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Change the bank count while the mapper is idle.
    task automatic set_bank_count(input logic [BANK_CNT_W-1:0] value);
        drain_requests();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        bank_count_cfg = value;
    endtask

    // Five serial writes that commit a value to one register; reads may fall in between.
    task automatic load_register(input t_reg_sel sel, input logic [REG_W-1:0] value,
                                 input bit mix_reads);
        for (int i = 0; i < LOADER_WRITES; i++) begin
            if (mix_reads && $urandom_range(0, 3) == 0)
                send_request(REQ_PPU_READ, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
            send_request(REQ_CPU_WRITE, {1'b1, sel, 13'($urandom)},
                         {1'b0, 6'($urandom), value[i]});
        end
    endtask

    // One random item: a well-formed register load, a broken load, a plain access or noise.
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            load_register(t_reg_sel'($urandom_range(0, 3)), 5'($urandom), 1'b1);
        end else if (pick < 40) begin
            // Broken sequence: a partial load cut short by a loader reset.
            repeat ($urandom_range(1, 4))
                send_request(REQ_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                             {1'b0, 7'($urandom)});
            send_request(REQ_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                         {1'b1, 7'($urandom)});
        end else if (pick < 65) begin
            send_request(REQ_CPU_READ, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
        end else if (pick < 75) begin
            send_request(2'($urandom), 16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
        end else if (pick < 90) begin
            send_request(REQ_PPU_READ | 2'($urandom_range(0, 1)),
                         16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        end else begin
            send_request(2'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // Accesses right after reset: every region and the field extremes.
    task automatic test_power_on_map();
        send_request(REQ_CPU_READ, 16'h8000, 8'h00);
        send_request(REQ_CPU_READ, 16'hFFFF, 8'hFF);
        send_request(REQ_CPU_READ, 16'h0000, 8'h00);
        send_request(REQ_CPU_WRITE, 16'h6000, 8'hFF);
        send_request(REQ_CPU_READ, 16'h7FFF, 8'h00);
        send_request(REQ_PPU_READ, 16'h0000, 8'h00);
        send_request(REQ_PPU_WRITE, 16'h1FFF, 8'hA5);
        send_request(REQ_PPU_READ, 16'h2000, 8'h00);
        send_request(REQ_PPU_WRITE, 16'hFFFF, 8'hFF);
    endtask

    // Loader reset in the middle of a load, then control and program loads.
    task automatic test_serial_loader();
        send_request(REQ_CPU_WRITE, 16'h8000, 8'h01);
        send_request(REQ_CPU_WRITE, 16'h8000, 8'h7F);
        send_request(REQ_CPU_WRITE, 16'hFFFF, 8'hFF);
        load_register(SEL_CONTROL, 5'h13, 1'b0);
        load_register(SEL_PROGRAM, 5'h1F, 1'b0);
        send_request(REQ_CPU_READ, 16'h8000, 8'h00);
        send_request(REQ_CPU_READ, 16'hC000, 8'h00);
    endtask

    // Random traffic under one bank count setting.
    task automatic test_random_phase(input logic [BANK_CNT_W-1:0] count, input int n_items);
        set_bank_count(count);
        for (int i = 0; i < n_items; i++) send_random_item();
    endtask

    // Random traffic with no idling on either side.
    task automatic test_back_to_back();
        drain_requests();
        no_idle = 1'b1;
        for (int i = 0; i < 15; i++) send_random_item();
        drain_requests();
        no_idle = 1'b0;
    endtask

    initial begin
        ld_shift       = '0;
        ld_count       = '0;
        ctrl_reg       = CTRL_RESET;
        chr_lo         = '0;
        chr_hi         = '0;
        prg_sel        = '0;
        bank_count_cfg = BANK_CNT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_map();
        test_serial_loader();
        test_random_phase(BANK_CNT_RESET, 20);
        test_random_phase(BANK_CNT_MIN, 20);
        test_random_phase(5'd0, 20);
        test_random_phase(5'd31, 20);
        test_random_phase(5'd17, 15);
        test_random_phase(5'($urandom_range(2, 15)), 20);
        test_random_phase(BANK_CNT_MAX, 15);
        test_back_to_back();

        drain_requests();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_maps.size() == 0) begin
            $display("serial_bank_switch_mapper test passed");
        end else begin
            $display("serial_bank_switch_mapper test failed");
        end
        $finish;
    end

endmodule

>>> serial_bank_switch_mapper.f
+incdir+sv
sv/sbsm_pkg.sv
sv/serial_bank_switch_mapper.sv
sv/sbsm_checker.sv
verif/tb_serial_bank_switch_mapper.sv
